>>> rtl/gbe_pkg.sv
package gbe_pkg;

   localparam int MaxGlyphWidth  = 32;
   localparam int MaxGlyphHeight = 32;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 32;

   localparam logic [CsrIndexWidth-1:0] CSR_LAYER_SELECT     = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_LAYER_ONE_BASE   = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_LAYER_TWO_BASE   = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_LINE_WIDTH       = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_GLYPH_WIDTH      = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_GLYPH_HEIGHT     = 3'd5;
   localparam logic [CsrIndexWidth-1:0] CSR_PAPER_COLOR      = 3'd6;
   localparam logic [CsrIndexWidth-1:0] CSR_INK_COLOR        = 3'd7;

   localparam logic [1:0] KIND_FONT_READ = 2'd0;
   localparam logic [1:0] KIND_PIXEL     = 2'd1;
   localparam logic [1:0] KIND_CONTROL   = 2'd2;

   localparam logic [1:0]  LAYER_ONE       = 2'd1;
   localparam logic [1:0]  LAYER_TWO       = 2'd2;
   localparam logic [7:0]  FIRST_PRINTABLE = 8'd32;
   localparam logic [3:0]  BITS_PER_BYTE   = 4'd8;
   localparam logic [31:0] PIXEL_BYTES     = 32'd4;

   typedef struct packed {
      logic [1:0]  layer_select;
      logic [31:0] layer_one_base;
      logic [31:0] layer_two_base;
      logic [11:0] line_width;
      logic [5:0]  glyph_width;
      logic [5:0]  glyph_height;
      logic [31:0] paper_color;
      logic [31:0] ink_color;
   } cfg_type;

   typedef struct packed {
      logic cap_in;
      logic start_origin;
      logic start_finish;
      logic byte_begin;
      logic pix_load;
      logic end_row;
      logic set_skip;
   } cmd_type;

   typedef struct packed {
      logic operation;
      logic active;
      logic skip;
      logic pixels_zero;
      logic bits_zero;
      logic more_pixels;
   } status_type;

endpackage

>>> rtl/gbe_if.sv
interface gbe_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [7:0]  symbol;
   logic [23:0] start_pixel;
   logic        follow_previous;
   logic [7:0]  glyph_byte;

   modport source (
      output valid, operation, symbol, start_pixel, follow_previous, glyph_byte,
      input  ready
   );
   modport sink (
      input  valid, operation, symbol, start_pixel, follow_previous, glyph_byte,
      output ready
   );
endinterface

interface gbe_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [15:0] font_offset;
   logic [31:0] pixel_address;
   logic [31:0] pixel_color;
   logic        last;

   modport source (
      output valid, kind, font_offset, pixel_address, pixel_color, last,
      input  ready
   );
   modport sink (
      input  valid, kind, font_offset, pixel_address, pixel_color, last,
      output ready
   );
endinterface

>>> rtl/glyph_bitmap_expander.sv
// Start transaction: one result, after origin and first multiply, then offset
//   multiply; next transaction taken once it is consumed.
// Font byte: pixel writes after a decode step, one write per cycle while the
//   receiver takes them, from the single result register.
// Synchronous active-high reset: state and glyph registers to defaults, no glyph in progress.
module glyph_bitmap_expander #(
   parameter int MAX_GLYPH_WIDTH  = gbe_pkg::MaxGlyphWidth,
   parameter int MAX_GLYPH_HEIGHT = gbe_pkg::MaxGlyphHeight
) (
   input  logic                                 clock,
   input  logic                                 reset,
   gbe_req_if.sink                              req_ch,
   gbe_rsp_if.source                            rsp_ch,
   input  logic                                 csr_write_enable,
   input  logic [gbe_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [gbe_pkg::CsrDataWidth-1:0]     csr_write_data
);

   gbe_pkg::cfg_type    cfg;
   gbe_pkg::cmd_type    cmd;
   gbe_pkg::status_type status;

   gbe_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   gbe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   gbe_dpath #(
      .MAX_GLYPH_WIDTH  (MAX_GLYPH_WIDTH),
      .MAX_GLYPH_HEIGHT (MAX_GLYPH_HEIGHT)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg),
      .cmd                 (cmd),
      .status              (status),
      .req_operation       (req_ch.operation),
      .req_symbol          (req_ch.symbol),
      .req_start_pixel     (req_ch.start_pixel),
      .req_follow_previous (req_ch.follow_previous),
      .req_glyph_byte      (req_ch.glyph_byte),
      .rsp_kind            (rsp_ch.kind),
      .rsp_font_offset     (rsp_ch.font_offset),
      .rsp_pixel_address   (rsp_ch.pixel_address),
      .rsp_pixel_color     (rsp_ch.pixel_color),
      .rsp_last            (rsp_ch.last)
   );

endmodule

>>> rtl/gbe_csr.sv
module gbe_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [gbe_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [gbe_pkg::CsrDataWidth-1:0]     csr_write_data,
   output gbe_pkg::cfg_type                     cfg
);

   gbe_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            gbe_pkg::CSR_LAYER_SELECT:     cfg_in.layer_select     = csr_write_data[1:0];
            gbe_pkg::CSR_LAYER_ONE_BASE:   cfg_in.layer_one_base   = csr_write_data;
            gbe_pkg::CSR_LAYER_TWO_BASE:   cfg_in.layer_two_base   = csr_write_data;
            gbe_pkg::CSR_LINE_WIDTH:       cfg_in.line_width       = csr_write_data[11:0];
            gbe_pkg::CSR_GLYPH_WIDTH:      cfg_in.glyph_width      = csr_write_data[5:0];
            gbe_pkg::CSR_GLYPH_HEIGHT:     cfg_in.glyph_height     = csr_write_data[5:0];
            gbe_pkg::CSR_PAPER_COLOR:      cfg_in.paper_color      = csr_write_data;
            gbe_pkg::CSR_INK_COLOR:        cfg_in.ink_color        = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.layer_select     <= gbe_pkg::LAYER_ONE;
         cfg_ff.layer_one_base   <= 32'd0;
         cfg_ff.layer_two_base   <= 32'd0;
         cfg_ff.line_width       <= 12'd240;
         cfg_ff.glyph_width      <= 6'd11;
         cfg_ff.glyph_height     <= 6'd16;
         cfg_ff.paper_color      <= 32'd0;
         cfg_ff.ink_color        <= 32'hFFFF_FFFF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/gbe_ctrl.sv
module gbe_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  gbe_pkg::status_type    status,
   output gbe_pkg::cmd_type       cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_FINISH = 3'd2;
   localparam logic [2:0] S_OUT    = 3'd3;
   localparam logic [2:0] S_PIX    = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       out_valid_ff, out_valid_in;
   logic       out_free;

   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      out_valid_in = out_valid_ff;
      req_ready    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.cap_in = 1'b1;
               state_in   = S_DECODE;
            end
         end
         S_DECODE: begin
            if (!status.operation) begin
               cmd.start_origin = 1'b1;
               state_in         = S_FINISH;
            end else if (!status.active) begin
               state_in = S_IDLE;
            end else if (status.skip || status.pixels_zero) begin
               // padding byte, or a row with nothing to draw
               cmd.end_row = 1'b1;
               state_in    = S_IDLE;
            end else begin
               cmd.byte_begin = 1'b1;
               state_in       = S_PIX;
            end
         end
         S_FINISH: begin
            cmd.start_finish = 1'b1;
            out_valid_in     = 1'b1;
            state_in         = S_OUT;
         end
         S_OUT: begin
            if (rsp_ready) begin
               out_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         S_PIX: begin
            if (out_free) begin
               if (status.more_pixels) begin
                  cmd.pix_load = 1'b1;
                  out_valid_in = 1'b1;
               end else begin
                  // last write of the byte taken: settle the row if it is complete
                  out_valid_in = 1'b0;
                  state_in     = S_IDLE;
                  if (status.pixels_zero) begin
                     if (status.bits_zero) begin
                        cmd.set_skip = 1'b1;
                     end else begin
                        cmd.end_row = 1'b1;
                     end
                  end
               end
            end
         end
         default: begin
            state_in     = S_IDLE;
            out_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

>>> rtl/gbe_dpath.sv
module gbe_dpath #(
   parameter int MAX_GLYPH_WIDTH  = gbe_pkg::MaxGlyphWidth,
   parameter int MAX_GLYPH_HEIGHT = gbe_pkg::MaxGlyphHeight
) (
   input  logic                   clock,
   input  logic                   reset,
   input  gbe_pkg::cfg_type       cfg,
   input  gbe_pkg::cmd_type       cmd,
   output gbe_pkg::status_type    status,
   input  logic                   req_operation,
   input  logic [7:0]             req_symbol,
   input  logic [23:0]            req_start_pixel,
   input  logic                   req_follow_previous,
   input  logic [7:0]             req_glyph_byte,
   output logic [1:0]             rsp_kind,
   output logic [15:0]            rsp_font_offset,
   output logic [31:0]            rsp_pixel_address,
   output logic [31:0]            rsp_pixel_color,
   output logic                   rsp_last
);

   // captured transaction
   logic        op_ff, op_in;
   logic [7:0]  symbol_ff, symbol_in;
   logic [23:0] start_ff, start_in;
   logic        follow_ff, follow_in;
   logic [7:0]  byte_ff, byte_in;

   // glyph state
   logic [23:0] origin_ff, origin_in;
   logic [31:0] write_address_ff, write_address_in;
   logic [5:0]  rows_left_ff, rows_left_in;
   logic [5:0]  pixels_left_ff, pixels_left_in;
   logic [3:0]  bits_left_ff, bits_left_in;
   logic        skip_ff, skip_in;
   logic        active_ff, active_in;

   logic [13:0] product_ff, product_in;
   logic        ctrl_char_ff, ctrl_char_in;
   logic [31:0] stride_ff, stride_in;

   // result register
   logic [1:0]  kind_ff, kind_in;
   logic [15:0] offset_ff, offset_in;
   logic [31:0] address_ff, address_in;
   logic [31:0] color_ff, color_in;
   logic        last_ff, last_in;

   logic [5:0]  width_eff, height_eff;
   logic [3:0]  bytes_per_row;
   logic [7:0]  symbol_index;
   logic [17:0] offset_full;
   logic [31:0] glyph_base, glyph_address, stride_diff;
   logic [2:0]  bit_idx;
   logic [5:0]  rows_dec;

   function automatic logic [7:0] req_sym_sub(input logic [7:0] sym);
      req_sym_sub = sym - gbe_pkg::FIRST_PRINTABLE;
   endfunction

   always_comb begin
      width_eff  = (int'(cfg.glyph_width) > MAX_GLYPH_WIDTH) ?
                   6'(MAX_GLYPH_WIDTH) : cfg.glyph_width;
      height_eff = (int'(cfg.glyph_height) > MAX_GLYPH_HEIGHT) ?
                   6'(MAX_GLYPH_HEIGHT) : cfg.glyph_height;
      bytes_per_row = {1'b0, width_eff[5:3]} + 4'd1;
      symbol_index  = req_sym_sub(symbol_ff);
      offset_full   = {4'd0, product_ff} * {14'd0, bytes_per_row};
      glyph_base    = (cfg.layer_select == gbe_pkg::LAYER_TWO) ?
                      cfg.layer_two_base : cfg.layer_one_base;
      glyph_address = glyph_base + {6'd0, origin_ff, 2'b00};
      // row skip may go negative; wraps mod 2^32
      stride_diff   = {20'd0, cfg.line_width} - {26'd0, width_eff};
      stride_in     = {stride_diff[29:0], 2'b00};
      bit_idx       = 3'(bits_left_ff - 4'd1);
      rows_dec      = rows_left_ff - 6'd1;
   end

   always_comb begin
      op_in     = op_ff;
      symbol_in = symbol_ff;
      start_in  = start_ff;
      follow_in = follow_ff;
      byte_in   = byte_ff;

      origin_in        = origin_ff;
      write_address_in = write_address_ff;
      rows_left_in     = rows_left_ff;
      pixels_left_in   = pixels_left_ff;
      bits_left_in     = bits_left_ff;
      skip_in          = skip_ff;
      active_in        = active_ff;
      product_in       = product_ff;
      ctrl_char_in     = ctrl_char_ff;

      kind_in    = kind_ff;
      offset_in  = offset_ff;
      address_in = address_ff;
      color_in   = color_ff;
      last_in    = last_ff;

      if (cmd.cap_in) begin
         op_in     = req_operation;
         symbol_in = req_symbol;
         start_in  = req_start_pixel;
         follow_in = req_follow_previous;
         byte_in   = req_glyph_byte;
      end

      if (cmd.start_origin) begin
         origin_in    = follow_ff ? 24'(origin_ff + {18'd0, width_eff}) : start_ff;
         ctrl_char_in = symbol_ff < gbe_pkg::FIRST_PRINTABLE;
         product_in   = {6'd0, symbol_index} * {8'd0, height_eff};
      end

      if (cmd.start_finish) begin
         last_in  = 1'b1;
         color_in = 32'd0;
         if (ctrl_char_ff) begin
            active_in  = 1'b0;
            kind_in    = gbe_pkg::KIND_CONTROL;
            offset_in  = 16'd0;
            address_in = 32'd0;
         end else begin
            write_address_in = glyph_address;
            rows_left_in     = height_eff;
            pixels_left_in   = width_eff;
            bits_left_in     = gbe_pkg::BITS_PER_BYTE;
            skip_in          = 1'b0;
            active_in        = (height_eff != 6'd0);
            kind_in          = gbe_pkg::KIND_FONT_READ;
            offset_in        = offset_full[15:0];
            address_in       = glyph_address;
         end
      end

      if (cmd.byte_begin) begin
         bits_left_in = gbe_pkg::BITS_PER_BYTE;
      end

      if (cmd.pix_load) begin
         kind_in          = gbe_pkg::KIND_PIXEL;
         offset_in        = 16'd0;
         address_in       = write_address_ff;
         color_in         = byte_ff[bit_idx] ? cfg.ink_color : cfg.paper_color;
         last_in          = (pixels_left_ff == 6'd1) || (bits_left_ff == 4'd1);
         write_address_in = write_address_ff + gbe_pkg::PIXEL_BYTES;
         pixels_left_in   = pixels_left_ff - 6'd1;
         bits_left_in     = bits_left_ff - 4'd1;
      end

      if (cmd.end_row) begin
         write_address_in = write_address_ff + stride_ff;
         pixels_left_in   = width_eff;
         bits_left_in     = gbe_pkg::BITS_PER_BYTE;
         skip_in          = 1'b0;
         rows_left_in     = rows_dec;
         if (rows_dec == 6'd0) begin
            active_in = 1'b0;
         end
      end

      if (cmd.set_skip) begin
         skip_in      = 1'b1;
         bits_left_in = gbe_pkg::BITS_PER_BYTE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff        <= 24'd0;
         write_address_ff <= 32'd0;
         rows_left_ff     <= 6'd0;
         pixels_left_ff   <= 6'd0;
         bits_left_ff     <= gbe_pkg::BITS_PER_BYTE;
         skip_ff          <= 1'b0;
         active_ff        <= 1'b0;
         ctrl_char_ff     <= 1'b0;
      end else begin
         origin_ff        <= origin_in;
         write_address_ff <= write_address_in;
         rows_left_ff     <= rows_left_in;
         pixels_left_ff   <= pixels_left_in;
         bits_left_ff     <= bits_left_in;
         skip_ff          <= skip_in;
         active_ff        <= active_in;
         ctrl_char_ff     <= ctrl_char_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      symbol_ff  <= symbol_in;
      start_ff   <= start_in;
      follow_ff  <= follow_in;
      byte_ff    <= byte_in;
      product_ff <= product_in;
      stride_ff  <= stride_in;
      kind_ff    <= kind_in;
      offset_ff  <= offset_in;
      address_ff <= address_in;
      color_ff   <= color_in;
      last_ff    <= last_in;
   end

   always_comb begin
      status.operation   = op_ff;
      status.active      = active_ff;
      status.skip        = skip_ff;
      status.pixels_zero = (pixels_left_ff == 6'd0);
      status.bits_zero   = (bits_left_ff == 4'd0);
      status.more_pixels = (pixels_left_ff != 6'd0) && (bits_left_ff != 4'd0);
   end

   assign rsp_kind          = kind_ff;
   assign rsp_font_offset   = offset_ff;
   assign rsp_pixel_address = address_ff;
   assign rsp_pixel_color   = color_ff;
   assign rsp_last          = last_ff;

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam logic OP_START      = 1'b0;
   localparam logic OP_FONT_BYTE  = 1'b1;
   localparam int   SETTLE_CYCLES = 24;
   localparam int   WATCHDOG_LIMIT = 2000;
   localparam int   LONG_HOLD     = 240;
   localparam int   PHASE_ITEMS   = 34;

   typedef struct packed {
      logic        operation;
      logic [7:0]  symbol;
      logic [23:0] start_pixel;
      logic        follow_previous;
      logic [7:0]  glyph_byte;
   } glyph_req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] font_offset;
      logic [31:0] pixel_address;
      logic [31:0] pixel_color;
      logic        last;
   } draw_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              csr_write_enable = 1'b0;
   logic [gbe_pkg::CsrIndexWidth-1:0] csr_index = '0;
   logic [gbe_pkg::CsrDataWidth-1:0]  csr_write_data = '0;

   gbe_req_if req_bus ();
   gbe_rsp_if rsp_bus ();

   glyph_bitmap_expander uut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_bus),
      .rsp_ch           (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #6 clock = ~clock;

   // Predicted blitter state and register copy
   gbe_pkg::cfg_type pr_cfg;
   logic [31:0] pr_write_addr;
   logic [23:0] pr_origin;
   logic [5:0]  pr_rows_left;
   logic [5:0]  pr_pixels_left;
   logic [3:0]  pr_bit_pos;
   logic        pr_skip_pad;
   logic        pr_active;

   draw_type draws_due[$];
   draw_type got_draw, want_draw;

   int error_count  = 0;
   int tx_idle_pct  = 0;
   int rx_idle_pct  = 0;
   int hold_request = 0;
   int stall_left   = 0;
   int quiet_cycles = 0;

   function automatic logic [5:0] used_width();
      return (pr_cfg.glyph_width < gbe_pkg::MaxGlyphWidth) ? pr_cfg.glyph_width
                                                          : 6'(gbe_pkg::MaxGlyphWidth);
   endfunction

   function automatic logic [5:0] used_height();
      return (pr_cfg.glyph_height < gbe_pkg::MaxGlyphHeight) ? pr_cfg.glyph_height
                                                            : 6'(gbe_pkg::MaxGlyphHeight);
   endfunction

   function automatic int bytes_per_row();
      return int'(used_width() / gbe_pkg::BITS_PER_BYTE) + 1;
   endfunction

   task automatic reset_predictor();
      pr_cfg.layer_select   = gbe_pkg::LAYER_ONE;
      pr_cfg.layer_one_base = 32'd0;
      pr_cfg.layer_two_base = 32'd0;
      pr_cfg.line_width     = 12'd240;
      pr_cfg.glyph_width    = 6'd11;
      pr_cfg.glyph_height   = 6'd16;
      pr_cfg.paper_color    = 32'd0;
      pr_cfg.ink_color      = 32'hFFFF_FFFF;
      pr_write_addr  = 32'd0;
      pr_origin      = 24'd0;
      pr_rows_left   = 6'd0;
      pr_pixels_left = 6'd0;
      pr_bit_pos     = gbe_pkg::BITS_PER_BYTE;
      pr_skip_pad    = 1'b0;
      pr_active      = 1'b0;
   endtask

   task automatic finish_row();
      logic [5:0] w;
      w = used_width();
      pr_write_addr  = pr_write_addr
                       + gbe_pkg::PIXEL_BYTES * (32'(pr_cfg.line_width) - 32'(w));
      pr_pixels_left = w;
      pr_bit_pos     = gbe_pkg::BITS_PER_BYTE;
      pr_skip_pad    = 1'b0;
      pr_rows_left   = pr_rows_left - 6'd1;
      if (pr_rows_left == 6'd0)
         pr_active = 1'b0;
   endtask

   task automatic predict_draws(input glyph_req_type it);
      logic [5:0]  w;
      logic [5:0]  h;
      logic [31:0] base;
      logic [31:0] product;
      draw_type    d;
      int          n;
      w = used_width();
      h = used_height();
      n = 0;
      if (it.operation == OP_START) begin
         base = (pr_cfg.layer_select == gbe_pkg::LAYER_TWO) ? pr_cfg.layer_two_base
                                                            : pr_cfg.layer_one_base;
         pr_origin = it.follow_previous ? pr_origin + 24'(w) : it.start_pixel;
         if (it.symbol < gbe_pkg::FIRST_PRINTABLE) begin
            pr_active = 1'b0;
            d = '{kind: gbe_pkg::KIND_CONTROL, font_offset: 16'd0, pixel_address: 32'd0,
                  pixel_color: 32'd0, last: 1'b1};
            draws_due.push_back(d);
            return;
         end
         pr_write_addr  = base + gbe_pkg::PIXEL_BYTES * 32'(pr_origin);
         pr_rows_left   = h;
         pr_pixels_left = w;
         pr_bit_pos     = gbe_pkg::BITS_PER_BYTE;
         pr_skip_pad    = 1'b0;
         pr_active      = (h != 6'd0);
         product = 32'(it.symbol - gbe_pkg::FIRST_PRINTABLE) * 32'(h)
                   * (32'(w / gbe_pkg::BITS_PER_BYTE) + 1);
         d = '{kind: gbe_pkg::KIND_FONT_READ, font_offset: product[15:0],
               pixel_address: pr_write_addr, pixel_color: 32'd0, last: 1'b1};
         draws_due.push_back(d);
         return;
      end
      if (!pr_active)
         return;
      if (pr_skip_pad) begin
         finish_row();
         return;
      end
      if (pr_bit_pos == 4'd0 || pr_bit_pos > gbe_pkg::BITS_PER_BYTE)
         pr_bit_pos = gbe_pkg::BITS_PER_BYTE;
      while (pr_pixels_left > 6'd0 && pr_bit_pos > 4'd0) begin
         d.kind          = gbe_pkg::KIND_PIXEL;
         d.font_offset   = 16'd0;
         d.pixel_address = pr_write_addr;
         d.pixel_color   = it.glyph_byte[pr_bit_pos - 4'd1] ? pr_cfg.ink_color
                                                             : pr_cfg.paper_color;
         d.last          = 1'b0;
         draws_due.push_back(d);
         n++;
         pr_write_addr  = pr_write_addr + gbe_pkg::PIXEL_BYTES;
         pr_pixels_left = pr_pixels_left - 6'd1;
         pr_bit_pos     = pr_bit_pos - 4'd1;
      end
      if (n > 0)
         draws_due[draws_due.size() - 1].last = 1'b1;
      if (pr_pixels_left == 6'd0) begin
         if (pr_bit_pos == 4'd0) begin
            pr_skip_pad = 1'b1;
            pr_bit_pos  = gbe_pkg::BITS_PER_BYTE;
         end else begin
            finish_row();
         end
      end else if (pr_bit_pos == 4'd0) begin
         pr_bit_pos = gbe_pkg::BITS_PER_BYTE;
      end
   endtask

   // Called at a rising edge; returns at the edge that accepts the transaction.
   // valid is left high so a following send does not toggle it within one step.
   task automatic send_item(input glyph_req_type it);
      while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid           <= 1'b1;
      req_bus.operation       <= it.operation;
      req_bus.symbol          <= it.symbol;
      req_bus.start_pixel     <= it.start_pixel;
      req_bus.follow_previous <= it.follow_previous;
      req_bus.glyph_byte      <= it.glyph_byte;
      @(negedge clock);
      while (!req_bus.ready)
         @(negedge clock);
      @(posedge clock);
      predict_draws(it);
   endtask

   task automatic send_start(input logic [7:0] symbol, input logic [23:0] start_pixel,
                             input logic follow);
      glyph_req_type it;
      it.operation       = OP_START;
      it.symbol          = symbol;
      it.start_pixel     = start_pixel;
      it.follow_previous = follow;
      it.glyph_byte      = 8'($urandom);
      send_item(it);
   endtask

   // Start-only fields carry noise; the block must ignore them on a font byte
   task automatic send_byte(input logic [7:0] glyph_byte);
      glyph_req_type it;
      it.operation       = OP_FONT_BYTE;
      it.symbol          = 8'($urandom);
      it.start_pixel     = 24'($urandom);
      it.follow_previous = 1'($urandom);
      it.glyph_byte      = glyph_byte;
      send_item(it);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (draws_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [gbe_pkg::CsrIndexWidth-1:0] idx,
                            input logic [31:0] val);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      @(posedge clock);
      case (idx)
         gbe_pkg::CSR_LAYER_SELECT:   pr_cfg.layer_select   = val[1:0];
         gbe_pkg::CSR_LAYER_ONE_BASE: pr_cfg.layer_one_base = val;
         gbe_pkg::CSR_LAYER_TWO_BASE: pr_cfg.layer_two_base = val;
         gbe_pkg::CSR_LINE_WIDTH:     pr_cfg.line_width     = val[11:0];
         gbe_pkg::CSR_GLYPH_WIDTH:    pr_cfg.glyph_width    = val[5:0];
         gbe_pkg::CSR_GLYPH_HEIGHT:   pr_cfg.glyph_height   = val[5:0];
         gbe_pkg::CSR_PAPER_COLOR:    pr_cfg.paper_color    = val;
         gbe_pkg::CSR_INK_COLOR:      pr_cfg.ink_color      = val;
         default: ;
      endcase
   endtask

   task automatic apply_config(input gbe_pkg::cfg_type c);
      drain();
      write_reg(gbe_pkg::CSR_LAYER_SELECT,   32'(c.layer_select));
      write_reg(gbe_pkg::CSR_LAYER_ONE_BASE, c.layer_one_base);
      write_reg(gbe_pkg::CSR_LAYER_TWO_BASE, c.layer_two_base);
      write_reg(gbe_pkg::CSR_LINE_WIDTH,     32'(c.line_width));
      write_reg(gbe_pkg::CSR_GLYPH_WIDTH,    32'(c.glyph_width));
      write_reg(gbe_pkg::CSR_GLYPH_HEIGHT,   32'(c.glyph_height));
      write_reg(gbe_pkg::CSR_PAPER_COLOR,    c.paper_color);
      write_reg(gbe_pkg::CSR_INK_COLOR,      c.ink_color);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_idling(input int tx_pct, input int rx_pct);
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
   endtask

   // Asks the result side to stall; posted at the falling edge so the
   // receiver picks it up cleanly at the next rising edge.
   task automatic request_hold(input int cycles);
      req_bus.valid <= 1'b0;
      @(negedge clock);
      hold_request = cycles;
      @(posedge clock);
   endtask

   task automatic compare_field(input string name, input logic [31:0] exp_val,
                                input logic [31:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_val, act_val);
         error_count++;
      end
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_control_and_restart();
      // reset register values are in force here
      send_start(8'd0, 24'h000000, 1'b0);
      send_start(8'd31, 24'h123456, 1'b1);
      send_start(8'd255, 24'hFFFFFF, 1'b0);
      send_start(gbe_pkg::FIRST_PRINTABLE, 24'h000000, 1'b1);   // origin wraps past 2^24
      send_byte(8'hFF);
      send_byte(8'h00);
      send_start(8'd65, 24'h000010, 1'b0);             // abandons the glyph above
      send_byte(8'hA5);
   endtask

   task automatic test_padding_and_negative_stride();
      gbe_pkg::cfg_type c;
      c = '{layer_select: gbe_pkg::LAYER_TWO, layer_one_base: 32'h0000_1234,
            layer_two_base: 32'hFFFF_FFF0, line_width: 12'd0, glyph_width: 6'd8,
            glyph_height: 6'd2, paper_color: 32'hAAAA_5555,
            ink_color: 32'h5555_AAAA};
      apply_config(c);
      send_start(8'd65, 24'h000003, 1'b0);
      send_byte(8'h81);
      send_byte(8'hFF);   // padding
      send_byte(8'h7E);
      send_byte(8'h00);   // padding, ends glyph
      send_byte(8'hFF);   // stray
   endtask

   task automatic test_zero_sizes();
      gbe_pkg::cfg_type c;
      c = pr_cfg;
      c.glyph_width  = 6'd11;
      c.glyph_height = 6'd0;
      apply_config(c);
      send_start(8'd66, 24'h00_0100, 1'b0);
      send_byte(8'hFF);
      c.glyph_width  = 6'd0;
      c.glyph_height = 6'd2;
      apply_config(c);
      send_start(8'd67, 24'h00_0000, 1'b1);
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_byte(8'hFF);
   endtask

   task automatic test_oversize_glyph();
      gbe_pkg::cfg_type c;
      c = '{layer_select: 2'd0, layer_one_base: 32'hFFFF_FFFF, layer_two_base: 32'd0,
            line_width: 12'd4095, glyph_width: 6'd63, glyph_height: 6'd63,
            paper_color: 32'hFFFF_FFFF, ink_color: 32'h0000_0000};
      apply_config(c);
      send_start(8'd255, 24'hABCDEF, 1'b0);
      send_byte(8'h80);
      send_byte(8'h01);
      send_byte(8'hC3);
      send_byte(8'h3C);
      send_byte(8'h55);
      send_start(8'd126, 24'h000000, 1'b1);
   endtask

   task automatic test_config_mid_glyph();
      gbe_pkg::cfg_type c;
      c = '{layer_select: 2'd3, layer_one_base: 32'h8000_0000, layer_two_base: 32'h0000_0040,
            line_width: 12'd20, glyph_width: 6'd4, glyph_height: 6'd2,
            paper_color: 32'h0F0F_0F0F, ink_color: 32'hF0F0_F0F0};
      apply_config(c);
      send_start(8'd77, 24'h000005, 1'b0);
      send_byte(8'hF0);
      c.glyph_width = 6'd12;
      c.line_width  = 12'd16;
      apply_config(c);
      send_byte(8'h0F);
   endtask

   task automatic test_result_backpressure();
      gbe_pkg::cfg_type c;
      c = pr_cfg;
      c.layer_select = gbe_pkg::LAYER_ONE;
      c.line_width   = 12'd300;
      c.glyph_width  = 6'd32;
      c.glyph_height = 6'd3;
      apply_config(c);
      request_hold(LONG_HOLD);
      send_start(8'd90, 24'($urandom), 1'b0);
      repeat (3 * bytes_per_row()) send_byte(8'($urandom));
   endtask

   task automatic test_sender_pause();
      gbe_pkg::cfg_type c;
      set_idling(25, 71);
      c = pr_cfg;
      c.glyph_width  = 6'd11;
      c.glyph_height = 6'd4;
      apply_config(c);
      send_start(8'd100, 24'($urandom), 1'b0);
      repeat (4) send_byte(8'($urandom));
      drain();
      repeat (4) send_byte(8'($urandom));
   endtask

   task automatic send_random_glyph(ref int budget);
      logic [7:0] sym;
      int         nbytes;
      if ($urandom_range(99) < 8) begin
         send_byte(8'($urandom));   // noise, usually ignored
         return;
      end
      sym = ($urandom_range(9) == 0) ? 8'($urandom_range(31)) : 8'($urandom_range(32, 255));
      send_start(sym, 24'($urandom), 1'($urandom_range(3) == 0));
      budget--;
      nbytes = (sym < gbe_pkg::FIRST_PRINTABLE) ? 0 : int'(used_height()) * bytes_per_row();
      if ($urandom_range(9) == 0)
         nbytes = $urandom_range(nbytes);   // broken glyph, restarted by the next start
      for (int i = 0; i < nbytes && budget > 0; i++) begin
         send_byte(8'($urandom));
         budget--;
      end
   endtask

   task automatic test_random_text(input int tx_pct, input int rx_pct);
      gbe_pkg::cfg_type c;
      int               budget;
      set_idling(tx_pct, rx_pct);
      repeat (3) begin
         c.layer_select   = 2'($urandom_range(3));
         c.layer_one_base = $urandom;
         c.layer_two_base = $urandom;
         c.line_width     = 12'($urandom_range(4095));
         c.glyph_width    = ($urandom_range(9) == 0) ? 6'($urandom_range(63))
                                                     : 6'($urandom_range(1, 12));
         c.glyph_height   = ($urandom_range(9) == 0) ? 6'($urandom_range(63))
                                                     : 6'($urandom_range(1, 4));
         c.paper_color    = $urandom;
         c.ink_color      = $urandom;
         apply_config(c);
         budget = PHASE_ITEMS;
         while (budget > 0)
            send_random_glyph(budget);
      end
   endtask

   // ---------------------------------------------------------------- processes

   initial begin : rsp_ready_driver
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            stall_left   = hold_request;
            hold_request = 0;
         end
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // Outputs are stable between the falling and the next rising edge
   always @(negedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got_draw = '{kind: rsp_bus.kind, font_offset: rsp_bus.font_offset,
                      pixel_address: rsp_bus.pixel_address,
                      pixel_color: rsp_bus.pixel_color, last: rsp_bus.last};
         if (draws_due.size() == 0) begin
            $display("%0t: unexpected result, expected none actual kind %0d addr %h color %h",
                     $time, got_draw.kind, got_draw.pixel_address, got_draw.pixel_color);
            error_count++;
         end else begin
            want_draw = draws_due.pop_front();
            compare_field("kind", 32'(want_draw.kind), 32'(got_draw.kind));
            compare_field("font_offset", 32'(want_draw.font_offset), 32'(got_draw.font_offset));
            compare_field("pixel_address", want_draw.pixel_address, got_draw.pixel_address);
            compare_field("pixel_color", want_draw.pixel_color, got_draw.pixel_color);
            compare_field("last", 32'(want_draw.last), 32'(got_draw.last));
         end
      end
   end

   always @(negedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog, no transaction for %0d cycles, %0d results outstanding",
                  $time, quiet_cycles, draws_due.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      req_bus.valid           = 1'b0;
      req_bus.operation       = OP_START;
      req_bus.symbol          = 8'd0;
      req_bus.start_pixel     = 24'd0;
      req_bus.follow_previous = 1'b0;
      req_bus.glyph_byte      = 8'd0;
      reset_predictor();
      set_idling(25, 71);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_control_and_restart();
      test_padding_and_negative_stride();
      test_zero_sizes();
      test_oversize_glyph();
      test_config_mid_glyph();
      test_result_backpressure();
      test_sender_pause();
      test_random_text(25, 71);
      test_random_text(71, 25);
      test_random_text(0, 0);
      drain();

      if (error_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
